[design/clfs_pkg.sv]
`default_nettype none

package clfs_pkg;

  localparam int CmdWidth    = 2;
  localparam int PosWidth    = 4;
  localparam int ValueWidth  = 16;
  localparam int StatusWidth = 2;
  localparam int CountWidth  = 4;

  typedef enum logic [CmdWidth-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_READ     = 2'd2,
    CMD_TRAVERSE = 2'd3
  } cmd_t;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANGE    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP,
    ST_WALK,
    ST_INS_NODE,
    ST_INS_LINK,
    ST_RM_RD,
    ST_RM_UNLINK,
    ST_RM_FREE,
    ST_RD_RD,
    ST_RD_WB,
    ST_TR_RD,
    ST_TR_WB,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

[design/clfs_ram.sv]
`default_nettype none

module clfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[design/cursor_linked_list_free_stack.sv]
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_command, in_position, in_entry_value
// out_      output     out_valid/out_stall out_status, out_value, out_entry_count, out_last
//
// One item at a time. Insert, remove and read first walk from the head to the position,
// following one link per read, limited by the single read port of the link memory;
// an out-of-range item goes straight to its result. Traverse reads each entry in turn
// and gives one result for each, the last one marked by out_last.
// Reset is synchronous and empties the list; node memories are not cleared.
// A finished result waits in the output register while the next item is taken.

`default_nettype none

module cursor_linked_list_free_stack #(
  parameter int MAX_NODES = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [clfs_pkg::CmdWidth-1:0]       in_command,
  input  wire logic [clfs_pkg::PosWidth-1:0]       in_position,
  input  wire logic [clfs_pkg::ValueWidth-1:0]     in_entry_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [clfs_pkg::StatusWidth-1:0]    out_status,
  output logic      [clfs_pkg::ValueWidth-1:0]     out_value,
  output logic      [clfs_pkg::CountWidth-1:0]     out_entry_count,
  output logic                                     out_last
);

  // Node indices reach MAX_NODES, which stands for the null link.
  localparam int IdxW = $clog2(MAX_NODES + 1);
  localparam int AddrW = $clog2(MAX_NODES);
  localparam int CntW = $clog2(MAX_NODES + 1);
  localparam int CmpW = (CntW > clfs_pkg::PosWidth) ? CntW : clfs_pkg::PosWidth;
  localparam logic [IdxW-1:0] NullIdx = IdxW'(MAX_NODES);

  clfs_pkg::state_t  state_r, state_nxt;
  clfs_pkg::cmd_t    cmd_r, cmd_nxt;
  clfs_pkg::status_t res_status_r, res_status_nxt;
  clfs_pkg::status_t out_status_r, out_status_nxt;

  logic [IdxW-1:0] free_top_r, free_top_nxt;
  logic [IdxW-1:0] hw_r, hw_nxt;
  logic [IdxW-1:0] first_r, first_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [IdxW-1:0] cur_r, cur_nxt;
  logic [IdxW-1:0] prev_r, prev_nxt;
  logic [IdxW-1:0] fresh_r, fresh_nxt;
  logic [clfs_pkg::PosWidth-1:0] hops_r, hops_nxt;
  logic            pend_r, pend_nxt;
  logic            pos_zero_r, pos_zero_nxt;
  logic [CntW-1:0] rem_r, rem_nxt;
  logic [clfs_pkg::ValueWidth-1:0] x_r, x_nxt;
  logic [clfs_pkg::ValueWidth-1:0] res_value_r, res_value_nxt;
  logic            res_last_r, res_last_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [clfs_pkg::ValueWidth-1:0] out_value_r, out_value_nxt;
  logic [clfs_pkg::CountWidth-1:0] out_count_r, out_count_nxt;
  logic            out_last_r, out_last_nxt;

  logic                             link_we;
  logic [AddrW-1:0]                 link_waddr;
  logic [IdxW-1:0]                  link_wdata;
  logic [AddrW-1:0]                 link_raddr;
  logic [IdxW-1:0]                  link_rdata;
  logic                             val_we;
  logic [AddrW-1:0]                 val_waddr;
  logic [clfs_pkg::ValueWidth-1:0]  val_rdata;

  logic            accept;
  logic            out_free;
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] cnt_ext;
  logic            free_empty;
  logic [IdxW-1:0] cur_sel;

  clfs_ram #(
    .WIDTH(IdxW),
    .DEPTH(MAX_NODES)
  ) u_link_ram (
    .clk    (clk),
    .wr_en  (link_we),
    .wr_addr(link_waddr),
    .wr_data(link_wdata),
    .rd_addr(link_raddr),
    .rd_data(link_rdata)
  );

  clfs_ram #(
    .WIDTH(clfs_pkg::ValueWidth),
    .DEPTH(MAX_NODES)
  ) u_value_ram (
    .clk    (clk),
    .wr_en  (val_we),
    .wr_addr(val_waddr),
    .wr_data(x_r),
    .rd_addr(cur_r[AddrW-1:0]),
    .rd_data(val_rdata)
  );

  assign in_stall        = (state_r != clfs_pkg::ST_IDLE);
  assign accept          = in_valid && !in_stall;
  assign out_free        = !out_valid_r || !out_stall;
  assign pos_ext         = CmpW'(in_position);
  assign cnt_ext         = CmpW'(count_r);
  assign free_empty      = (free_top_r == NullIdx);
  // While walking, the link read of the previous cycle already names the next node.
  assign cur_sel         = pend_r ? link_rdata : cur_r;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_value       = out_value_r;
  assign out_entry_count = out_count_r;
  assign out_last        = out_last_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      clfs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (clfs_pkg::cmd_t'(in_command))
            clfs_pkg::CMD_INSERT: begin
              if (pos_ext > cnt_ext) begin
                state_nxt = clfs_pkg::ST_EMIT;
              end else if (!free_empty) begin
                state_nxt = clfs_pkg::ST_POP;
              end else if (hw_r != NullIdx) begin
                state_nxt = clfs_pkg::ST_WALK;
              end else begin
                state_nxt = clfs_pkg::ST_EMIT;
              end
            end
            clfs_pkg::CMD_REMOVE, clfs_pkg::CMD_READ: begin
              state_nxt = (pos_ext >= cnt_ext) ? clfs_pkg::ST_EMIT : clfs_pkg::ST_WALK;
            end
            clfs_pkg::CMD_TRAVERSE: begin
              state_nxt = (count_r == '0) ? clfs_pkg::ST_EMIT : clfs_pkg::ST_TR_RD;
            end
          endcase
        end
      end
      clfs_pkg::ST_POP: state_nxt = clfs_pkg::ST_WALK;
      clfs_pkg::ST_WALK: begin
        if (hops_r == '0) begin
          unique case (cmd_r)
            clfs_pkg::CMD_INSERT: state_nxt = clfs_pkg::ST_INS_NODE;
            clfs_pkg::CMD_REMOVE: state_nxt = clfs_pkg::ST_RM_RD;
            default:              state_nxt = clfs_pkg::ST_RD_RD;
          endcase
        end
      end
      clfs_pkg::ST_INS_NODE: begin
        state_nxt = pos_zero_r ? clfs_pkg::ST_EMIT : clfs_pkg::ST_INS_LINK;
      end
      clfs_pkg::ST_INS_LINK:  state_nxt = clfs_pkg::ST_EMIT;
      clfs_pkg::ST_RM_RD:     state_nxt = clfs_pkg::ST_RM_UNLINK;
      clfs_pkg::ST_RM_UNLINK: state_nxt = clfs_pkg::ST_RM_FREE;
      clfs_pkg::ST_RM_FREE:   state_nxt = clfs_pkg::ST_EMIT;
      clfs_pkg::ST_RD_RD:     state_nxt = clfs_pkg::ST_RD_WB;
      clfs_pkg::ST_RD_WB:     state_nxt = clfs_pkg::ST_EMIT;
      clfs_pkg::ST_TR_RD:     state_nxt = clfs_pkg::ST_TR_WB;
      clfs_pkg::ST_TR_WB:     state_nxt = clfs_pkg::ST_EMIT;
      clfs_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = res_last_r ? clfs_pkg::ST_IDLE : clfs_pkg::ST_TR_RD;
        end
      end
      default: state_nxt = clfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt        = cmd_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_last_nxt   = res_last_r;
    free_top_nxt   = free_top_r;
    hw_nxt         = hw_r;
    first_nxt      = first_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    fresh_nxt      = fresh_r;
    hops_nxt       = hops_r;
    pend_nxt       = pend_r;
    pos_zero_nxt   = pos_zero_r;
    rem_nxt        = rem_r;
    x_nxt          = x_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    link_we        = 1'b0;
    link_waddr     = cur_r[AddrW-1:0];
    link_wdata     = free_top_r;
    link_raddr     = cur_r[AddrW-1:0];
    val_we         = 1'b0;
    val_waddr      = fresh_r[AddrW-1:0];

    unique case (state_r)
      clfs_pkg::ST_IDLE: begin
        // The free stack's next link is read ahead for a possible insert.
        link_raddr = free_top_r[AddrW-1:0];
        if (accept) begin
          cmd_nxt        = clfs_pkg::cmd_t'(in_command);
          x_nxt          = in_entry_value;
          hops_nxt       = in_position;
          pos_zero_nxt   = (in_position == '0);
          cur_nxt        = first_r;
          prev_nxt       = NullIdx;
          pend_nxt       = 1'b0;
          rem_nxt        = count_r;
          res_value_nxt  = '0;
          res_last_nxt   = 1'b1;
          res_status_nxt = clfs_pkg::STATUS_OK;
          unique case (clfs_pkg::cmd_t'(in_command))
            clfs_pkg::CMD_INSERT: begin
              if (pos_ext > cnt_ext) begin
                res_status_nxt = clfs_pkg::STATUS_RANGE;
              end else if (!free_empty) begin
                fresh_nxt = free_top_r;
              end else if (hw_r != NullIdx) begin
                fresh_nxt = hw_r;
                hw_nxt    = IdxW'(hw_r + 1'b1);
              end else begin
                res_status_nxt = clfs_pkg::STATUS_OVERFLOW;
              end
            end
            clfs_pkg::CMD_REMOVE, clfs_pkg::CMD_READ: begin
              if (pos_ext >= cnt_ext) begin
                res_status_nxt = clfs_pkg::STATUS_RANGE;
              end
            end
            clfs_pkg::CMD_TRAVERSE: begin
              if (count_r == '0) begin
                res_status_nxt = clfs_pkg::STATUS_RANGE;
              end
            end
          endcase
        end
      end
      clfs_pkg::ST_POP: begin
        free_top_nxt = link_rdata;
      end
      clfs_pkg::ST_WALK: begin
        if (hops_r == '0) begin
          cur_nxt  = cur_sel;
          pend_nxt = 1'b0;
        end else begin
          link_raddr = cur_sel[AddrW-1:0];
          prev_nxt   = cur_sel;
          cur_nxt    = cur_sel;
          pend_nxt   = 1'b1;
          hops_nxt   = hops_r - 1'b1;
        end
      end
      clfs_pkg::ST_INS_NODE: begin
        // The walk ended on the node that will follow the new one.
        link_we    = 1'b1;
        link_waddr = fresh_r[AddrW-1:0];
        link_wdata = cur_r;
        val_we     = 1'b1;
        count_nxt  = CntW'(count_r + 1'b1);
        if (pos_zero_r) begin
          first_nxt = fresh_r;
        end
      end
      clfs_pkg::ST_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = prev_r[AddrW-1:0];
        link_wdata = fresh_r;
      end
      clfs_pkg::ST_RM_UNLINK: begin
        res_value_nxt = val_rdata;
        if (pos_zero_r) begin
          first_nxt = link_rdata;
        end else begin
          link_we    = 1'b1;
          link_waddr = prev_r[AddrW-1:0];
          link_wdata = link_rdata;
        end
      end
      clfs_pkg::ST_RM_FREE: begin
        link_we      = 1'b1;
        link_waddr   = cur_r[AddrW-1:0];
        link_wdata   = free_top_r;
        free_top_nxt = cur_r;
        count_nxt    = CntW'(count_r - 1'b1);
      end
      clfs_pkg::ST_RD_WB: begin
        res_value_nxt = val_rdata;
      end
      clfs_pkg::ST_TR_WB: begin
        res_value_nxt = val_rdata;
        res_last_nxt  = (rem_r == CntW'(1));
        rem_nxt       = CntW'(rem_r - 1'b1);
        cur_nxt       = link_rdata;
      end
      clfs_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_count_nxt  = clfs_pkg::CountWidth'(count_r);
          out_last_nxt   = res_last_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clfs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      free_top_r  <= NullIdx;
      hw_r        <= '0;
      first_r     <= NullIdx;
      count_r     <= '0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      free_top_r  <= free_top_nxt;
      hw_r        <= hw_nxt;
      first_r     <= first_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_last_r   <= res_last_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    fresh_r      <= fresh_nxt;
    hops_r       <= hops_nxt;
    pos_zero_r   <= pos_zero_nxt;
    rem_r        <= rem_nxt;
    x_r          <= x_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

`default_nettype wire
